FILE: rtl/sdlc_pkg.sv
// Shared types and constants for the SLIP deframer with length check.
// Used by sdlc_decode, sdlc_out_buf and slip_deframer_length_check.
// No dependencies.
`default_nettype none

package sdlc_pkg;

	// SLIP special byte codes: frame end, escape, and the two escaped forms.
	localparam logic [7:0] CODE_FEND  = 8'hC0;
	localparam logic [7:0] CODE_FESC  = 8'hDB;
	localparam logic [7:0] CODE_TFEND = 8'hDC;
	localparam logic [7:0] CODE_TFESC = 8'hDD;

	// Kind of a result item.
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status reported at each non-empty frame end.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_NO_ROOM   = 2'd2,
		ST_MISMATCH  = 2'd3
	} frame_status_t;

	// One result item.
	typedef struct packed {
		logic          item_kind;
		logic [7:0]    decoded_byte;
		logic [7:0]    byte_position;
		frame_status_t frame_status;
		logic [8:0]    decoded_count;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/sdlc_decode.sv
// Per-byte SLIP decode, frame state and length/status check.
// Depends on sdlc_pkg.
`default_nettype none

module sdlc_decode import sdlc_pkg::*; #(
	parameter int ENCODED_CAPACITY = 512
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	input  wire logic       store_refuses,
	output logic            res_valid,
	output result_t         res
);

	localparam int CNT_W = $clog2(ENCODED_CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(ENCODED_CAPACITY);

	logic             escape_q;
	logic             stopped_q;
	logic [7:0]       hdr_len_q;
	logic [8:0]       cnt_dec_q;
	logic [CNT_W-1:0] cnt_enc_q;

	logic       is_end;
	logic       enc_full;
	logic       len_reached;
	logic       emit;
	logic       bad_escape;
	logic       set_escape;
	logic [7:0] value;
	logic [8:0] hdr_plus1;
	logic [8:0] cnt_dec_inc;

	// Classify the incoming byte against the current frame state.
	always_comb begin
		is_end      = (rx_byte == CODE_FEND);
		enc_full    = (cnt_enc_q >= CAP);
		hdr_plus1   = {1'b0, hdr_len_q} + 9'd1;
		cnt_dec_inc = cnt_dec_q + 9'd1;
		len_reached = (cnt_dec_q != 9'd0) && (cnt_dec_q >= hdr_plus1);
		emit        = 1'b0;
		bad_escape  = 1'b0;
		set_escape  = 1'b0;
		value       = rx_byte;
		if (!is_end && !enc_full && !stopped_q && !len_reached) begin
			if (escape_q) begin
				case (rx_byte)
					CODE_TFEND: begin
						emit  = 1'b1;
						value = CODE_FEND;
					end
					CODE_TFESC: begin
						emit  = 1'b1;
						value = CODE_FESC;
					end
					default: bad_escape = 1'b1;
				endcase
			end else if (rx_byte == CODE_FESC) begin
				set_escape = 1'b1;
			end else begin
				emit = 1'b1;
			end
		end
	end

	// Build the result item.
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (is_end) begin
			res_valid         = (cnt_enc_q != '0);
			res.item_kind     = KIND_STATUS;
			res.decoded_count = cnt_dec_q;
			if (cnt_dec_q == 9'd0) begin
				res.frame_status = ST_TOO_SHORT;
			end else if (store_refuses) begin
				res.frame_status = ST_NO_ROOM;
			end else if (cnt_dec_q != hdr_plus1) begin
				res.frame_status = ST_MISMATCH;
			end else begin
				res.frame_status = ST_OK;
			end
		end else begin
			res_valid         = emit;
			res.item_kind     = KIND_DATA;
			res.decoded_byte  = value;
			res.byte_position = cnt_dec_q[7:0];
			res.frame_status  = ST_OK;
			res.decoded_count = cnt_dec_inc;
		end
	end

	// Frame state, updated only when an item is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q  <= 1'b0;
			stopped_q <= 1'b0;
			hdr_len_q <= '0;
			cnt_dec_q <= '0;
			cnt_enc_q <= '0;
		end else if (accept) begin
			if (is_end) begin
				escape_q  <= 1'b0;
				stopped_q <= 1'b0;
				hdr_len_q <= '0;
				cnt_dec_q <= '0;
				cnt_enc_q <= '0;
			end else if (!enc_full) begin
				cnt_enc_q <= cnt_enc_q + CNT_W'(1);
				if (set_escape) begin
					escape_q <= 1'b1;
				end
				if (bad_escape) begin
					escape_q  <= 1'b0;
					stopped_q <= 1'b1;
				end
				if (emit) begin
					escape_q  <= 1'b0;
					cnt_dec_q <= cnt_dec_inc;
					if (cnt_dec_q == 9'd0) begin
						hdr_len_q <= value;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sdlc_out_buf.sv
// Two-entry output register with skid stage for result items.
// Depends on sdlc_pkg.
`default_nettype none

module sdlc_out_buf import sdlc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         can_push,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    main_vld_q;
	logic    skid_vld_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop       = main_vld_q && out_ready;
	assign can_push  = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_vld_q || pop) begin
				main_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (pop) begin
			main_vld_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_vld_q || pop) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/slip_deframer_length_check.sv
// SLIP receive deframer with length-header check, top level.
//
// Input channel: one SLIP-encoded byte (rx_byte) per item, with store_refuses
// sampled on a frame-ending 0xC0. Handshake in_valid/in_ready.
// Output channel: zero or one result item per input item, either a decoded
// data byte with its position and running count, or a frame-end status.
// Handshake out_valid/out_ready.
//
// Throughput is one input item per cycle while in_ready is high. The decode is
// a single pass of logic from the input byte and the frame state into the
// output register, so every result is registered on its way to the outputs.
// A two-entry output buffer holds results while the receiver stalls.
// in_ready drops while both entries are full, whatever the waiting input
// item would produce, and rises again in the cycle after the receiver takes
// an item. With the receiver always ready, in_ready never drops.
// Reset clears the frame state (no escape pending, counts zero) and empties
// the output buffer. At most ENCODED_CAPACITY encoded bytes per frame are
// taken into account; later bytes up to the next 0xC0 are dropped.
// Depends on sdlc_pkg, sdlc_decode and sdlc_out_buf.
`default_nettype none

module slip_deframer_length_check import sdlc_pkg::*; #(
	parameter int ENCODED_CAPACITY = 512
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       store_refuses,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            item_kind,
	output logic [7:0]      decoded_byte,
	output logic [7:0]      byte_position,
	output logic [1:0]      frame_status,
	output logic [8:0]      decoded_count
);

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign accept = in_valid && in_ready;

	// Byte decode and frame state.
	sdlc_decode #(
		.ENCODED_CAPACITY(ENCODED_CAPACITY)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (rx_byte),
		.store_refuses(store_refuses),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Output register and skid stage.
	sdlc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && res_valid),
		.push_data(res),
		.can_push (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_res)
	);

	assign item_kind     = out_res.item_kind;
	assign decoded_byte  = out_res.decoded_byte;
	assign byte_position = out_res.byte_position;
	assign frame_status  = out_res.frame_status;
	assign decoded_count = out_res.decoded_count;

	// A full buffer always presents an item.
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no item on the output");

	// A status item carries no byte and no position.
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_kind == KIND_STATUS) |->
		(decoded_byte == 8'd0 && byte_position == 8'd0))
		else $error("status item with byte or position set");

	// A data item is counted one past its position and has no status.
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_kind == KIND_DATA) |->
		(decoded_count == {1'b0, byte_position} + 9'd1 && frame_status == ST_OK))
		else $error("data item count does not follow its position");

	// After a result enters the buffer, the output presents an item in the next cycle.
	a_buffer_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_valid) |=> out_valid)
		else $error("accepted result lost from the output buffer");

endmodule

`default_nettype wire
